### rtl/page_free_list_allocator_unit_defines.svh
// Assertion macros used by the page allocator top level.
`ifndef PAGE_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PFLA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define PFLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pfla_pkg.sv
// Shared constants, codes and types of the page allocator.
`default_nettype none

package pfla_pkg;

   localparam int PAGE_COUNT = 1024;
   localparam int PAGE_ID_W  = 10;
   localparam int FRESH_W    = 11;
   localparam int ROW_W      = 32;

   typedef logic [1:0]           func_type;
   typedef logic [1:0]           status_type;
   typedef logic [PAGE_ID_W-1:0] page_id_type;
   typedef logic [FRESH_W-1:0]   fresh_type;
   typedef logic [ROW_W-1:0]     row_type;

   localparam func_type FUNC_ALLOC = 2'd0;
   localparam func_type FUNC_FREE  = 2'd1;
   localparam func_type FUNC_ROW   = 2'd2;

   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_ZERO    = 2'd1;
   localparam status_type ST_ALREADY = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

   localparam fresh_type FRESH_LIMIT = fresh_type'(PAGE_COUNT);
   localparam fresh_type FRESH_FIRST = fresh_type'(1);

   // Request and state seen by the execute logic
   typedef struct packed {
      func_type    func;
      page_id_type page_id;
      page_id_type free_head;
      fresh_type   next_fresh;
      row_type     next_row;
      page_id_type head_link;
      logic        page_is_free;
   } exec_in_type;

   // State updates and result of one request
   typedef struct packed {
      logic        head_we;
      page_id_type head_next;
      logic        fresh_inc;
      logic        row_inc;
      logic        link_we;
      page_id_type link_addr;
      page_id_type link_data;
      logic        flag_we;
      page_id_type flag_addr;
      logic        flag_data;
      page_id_type res_page;
      status_type  status;
      row_type     row;
   } exec_out_type;

endpackage

`default_nettype wire

### rtl/pfla_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pfla_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/pfla_exec.sv
// Decode of one request into state updates and a result.
`default_nettype none

module pfla_exec (
   input  wire pfla_pkg::exec_in_type  exec_in,
   output pfla_pkg::exec_out_type      exec_out
);

   logic page_known;

   // A page below the bump counter has been handed out at least once
   assign page_known = ({1'b0, exec_in.page_id} < exec_in.next_fresh);

   always_comb begin
      exec_out           = '0;
      exec_out.status    = pfla_pkg::ST_DONE;
      exec_out.head_next = exec_in.free_head;
      exec_out.link_addr = exec_in.page_id;
      exec_out.link_data = exec_in.free_head;
      exec_out.flag_addr = exec_in.page_id;
      unique case (exec_in.func)
         pfla_pkg::FUNC_ALLOC: begin
            if (exec_in.free_head != '0) begin
               // Pop the free list head
               exec_out.res_page  = exec_in.free_head;
               exec_out.head_we   = 1'b1;
               exec_out.head_next = exec_in.head_link;
               exec_out.flag_we   = 1'b1;
               exec_out.flag_addr = exec_in.free_head;
               exec_out.flag_data = 1'b0;
            end else if (exec_in.next_fresh < pfla_pkg::FRESH_LIMIT) begin
               // Bump a fresh page; its free mark is written here first
               exec_out.res_page  = exec_in.next_fresh[pfla_pkg::PAGE_ID_W-1:0];
               exec_out.fresh_inc = 1'b1;
               exec_out.flag_we   = 1'b1;
               exec_out.flag_addr = exec_in.next_fresh[pfla_pkg::PAGE_ID_W-1:0];
               exec_out.flag_data = 1'b0;
            end else begin
               exec_out.status = pfla_pkg::ST_FULL;
            end
         end
         pfla_pkg::FUNC_FREE: begin
            if (exec_in.page_id == '0 || !page_known) begin
               exec_out.status = pfla_pkg::ST_ZERO;
            end else if (exec_in.page_is_free) begin
               exec_out.status = pfla_pkg::ST_ALREADY;
            end else begin
               // Push the page onto the free list
               exec_out.link_we   = 1'b1;
               exec_out.head_we   = 1'b1;
               exec_out.head_next = exec_in.page_id;
               exec_out.flag_we   = 1'b1;
               exec_out.flag_data = 1'b1;
            end
         end
         pfla_pkg::FUNC_ROW: begin
            exec_out.row     = exec_in.next_row;
            exec_out.row_inc = 1'b1;
         end
         default: begin
            // Unused code: no change, zero result
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/page_free_list_allocator_unit.sv
// Top level of the page free list allocator.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  request | req_func, req_page_id                   | start && !busy
//  result  | rsp_page_id_res, rsp_status, rsp_row_id | rsp_strobe, one cycle
//
// A request beat has two steps: the accept edge registers the request and
// issues the link and free-mark memory reads, the next edge applies the
// update and loads the result register. busy is high for the single cycle between,
// so no new beat is taken before the update, due to the registered memory reads.
// The result is on the ports in the cycle that starts at its update edge and
// is taken at the edge after it; the receiver cannot stall.
// Reset clears the list head, row counter and strobes and sets the bump counter to one at once; no clearing pass.
`default_nettype none
`include "page_free_list_allocator_unit_defines.svh"

module page_free_list_allocator_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire pfla_pkg::func_type           req_func,
   input  wire pfla_pkg::page_id_type        req_page_id,
   output logic                              rsp_strobe,
   output pfla_pkg::page_id_type             rsp_page_id_res,
   output pfla_pkg::status_type              rsp_status,
   output pfla_pkg::row_type                 rsp_row_id
);

   logic                   accept;
   logic                   stage_valid_ff;
   logic                   rsp_strobe_ff;
   pfla_pkg::func_type     func_ff;
   pfla_pkg::page_id_type  page_id_ff;
   pfla_pkg::page_id_type  free_head_ff;
   pfla_pkg::page_id_type  free_head_in;
   pfla_pkg::fresh_type    next_fresh_ff;
   pfla_pkg::fresh_type    next_fresh_in;
   pfla_pkg::row_type      next_row_ff;
   pfla_pkg::row_type      next_row_in;
   pfla_pkg::page_id_type  rsp_page_ff;
   pfla_pkg::status_type   rsp_status_ff;
   pfla_pkg::row_type      rsp_row_ff;
   pfla_pkg::page_id_type  head_link;
   logic                   flag_rd;
   pfla_pkg::exec_in_type  exec_in;
   pfla_pkg::exec_out_type exec_out;

   assign accept = start && !busy;
   assign busy   = stage_valid_ff;

   // Hold the request while its reads are in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         page_id_ff <= req_page_id;
      end
   end

   // Link store, read at the current head
   pfla_ram #(
      .WIDTH(pfla_pkg::PAGE_ID_W),
      .DEPTH(pfla_pkg::PAGE_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (stage_valid_ff && exec_out.link_we),
      .wr_addr (exec_out.link_addr),
      .wr_data (exec_out.link_data),
      .rd_addr (free_head_ff),
      .rd_data (head_link)
   );

   // Free-mark store, read at the requested page
   pfla_ram #(
      .WIDTH(1),
      .DEPTH(pfla_pkg::PAGE_COUNT)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (stage_valid_ff && exec_out.flag_we),
      .wr_addr (exec_out.flag_addr),
      .wr_data (exec_out.flag_data),
      .rd_addr (req_page_id),
      .rd_data (flag_rd)
   );

   assign exec_in = '{
      func:         func_ff,
      page_id:      page_id_ff,
      free_head:    free_head_ff,
      next_fresh:   next_fresh_ff,
      next_row:     next_row_ff,
      head_link:    head_link,
      page_is_free: flag_rd
   };

   pfla_exec u_exec (
      .exec_in  (exec_in),
      .exec_out (exec_out)
   );

   // Next values of the allocator state
   always_comb begin
      free_head_in  = free_head_ff;
      next_fresh_in = next_fresh_ff;
      next_row_in   = next_row_ff;
      if (stage_valid_ff) begin
         if (exec_out.head_we) begin
            free_head_in = exec_out.head_next;
         end
         if (exec_out.fresh_inc) begin
            next_fresh_in = pfla_pkg::fresh_type'(next_fresh_ff + 1'b1);
         end
         if (exec_out.row_inc) begin
            next_row_in = pfla_pkg::row_type'(next_row_ff + 1'b1);
         end
      end
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         free_head_ff   <= '0;
         next_fresh_ff  <= pfla_pkg::FRESH_FIRST;
         next_row_ff    <= '0;
      end else begin
         stage_valid_ff <= accept;
         rsp_strobe_ff  <= stage_valid_ff;
         free_head_ff   <= free_head_in;
         next_fresh_ff  <= next_fresh_in;
         next_row_ff    <= next_row_in;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         rsp_page_ff   <= exec_out.res_page;
         rsp_status_ff <= exec_out.status;
         rsp_row_ff    <= exec_out.row;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_page_id_res = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_row_id      = rsp_row_ff;

   `PFLA_ASSERT_NEXT(a_accept_busy, clock, reset, accept,
      busy && rsp_strobe == 1'b0, "accepted beat must make the unit busy")
   `PFLA_ASSERT_NEXT(a_stage_result, clock, reset, stage_valid_ff,
      rsp_strobe && !busy, "worked beat must give one result")
   `PFLA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe,
      !rsp_strobe, "result strobe lasts one cycle")
   `PFLA_ASSERT_SAME(a_full_zero, clock, reset,
      rsp_strobe && rsp_status == pfla_pkg::ST_FULL,
      rsp_page_id_res == '0, "out of pages must give page zero")
   `PFLA_ASSERT_SAME(a_fresh_range, clock, reset, 1'b1,
      next_fresh_ff != '0 && next_fresh_ff <= pfla_pkg::FRESH_LIMIT,
      "bump counter out of range")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench of the page free list allocator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pfla_pkg::*;

   localparam func_type FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DIRECTED_COUNT = 23;
   localparam int FILL_CAP = 3000;
   localparam int FULL_BEATS = 600;
   localparam int CALM_BEATS = 250;

   typedef struct packed {
      page_id_type page;
      status_type  status;
      row_type     row;
   } alloc_result_type;

   typedef struct packed {
      func_type    func;
      page_id_type page;
      logic        typed;
      page_id_type exp_page;
      status_type  exp_status;
      row_type     exp_row;
   } directed_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   func_type    req_func = FUNC_ALLOC;
   page_id_type req_page_id = '0;
   logic        rsp_strobe;
   page_id_type rsp_page_id_res;
   status_type  rsp_status;
   row_type     rsp_row_id;

   // Typed expectation riding along with a directed beat
   logic             use_typed = 1'b0;
   alloc_result_type typed_result = '0;

   // Mirror of the allocator state
   page_id_type list_head;
   fresh_type   fresh_page;
   row_type     row_counter;
   page_id_type link_of_page [PAGE_COUNT];
   logic        page_on_list [PAGE_COUNT];

   alloc_result_type pending_results [$];
   int error_count = 0;
   int cycle_count = 0;
   int beats_accepted = 0;
   int full_count = 0;
   int ignored_count = 0;
   int already_count = 0;
   int results_checked = 0;

   directed_beat_type directed_beats [DIRECTED_COUNT] = '{
      '{FUNC_ROW,    10'd0,     1'b1, 10'd0, ST_DONE,    32'd0},
      '{FUNC_ROW,    10'd1023,  1'b1, 10'd0, ST_DONE,    32'd1},
      '{FUNC_ALLOC,  10'd0,     1'b1, 10'd1, ST_DONE,    32'd0},
      '{FUNC_ALLOC,  10'd1023,  1'b1, 10'd2, ST_DONE,    32'd0},
      '{FUNC_ALLOC,  10'd0,     1'b1, 10'd3, ST_DONE,    32'd0},
      '{FUNC_FREE,   10'd0,     1'b1, 10'd0, ST_ZERO,    32'd0},
      '{FUNC_FREE,   10'd1023,  1'b1, 10'd0, ST_ZERO,    32'd0},
      '{FUNC_FREE,   10'd4,     1'b1, 10'd0, ST_ZERO,    32'd0},
      '{FUNC_FREE,   10'd2,     1'b1, 10'd0, ST_DONE,    32'd0},
      '{FUNC_FREE,   10'd2,     1'b1, 10'd0, ST_ALREADY, 32'd0},
      '{FUNC_FREE,   10'd1,     1'b1, 10'd0, ST_DONE,    32'd0},
      '{FUNC_FREE,   10'd3,     1'b0, 10'd0, ST_DONE,    32'd0},
      '{FUNC_ALLOC,  10'd0,     1'b0, 10'd0, ST_DONE,    32'd0},
      '{FUNC_ALLOC,  10'd0,     1'b0, 10'd0, ST_DONE,    32'd0},
      '{FUNC_ALLOC,  10'd0,     1'b0, 10'd0, ST_DONE,    32'd0},
      '{FUNC_ALLOC,  10'd0,     1'b0, 10'd0, ST_DONE,    32'd0},
      '{FUNC_UNUSED, 10'd1023,  1'b1, 10'd0, ST_DONE,    32'd0},
      '{FUNC_UNUSED, 10'd0,     1'b1, 10'd0, ST_DONE,    32'd0},
      '{FUNC_FREE,   10'd4,     1'b0, 10'd0, ST_DONE,    32'd0},
      '{FUNC_FREE,   10'h155,   1'b1, 10'd0, ST_ZERO,    32'd0},
      '{FUNC_FREE,   10'h2AA,   1'b1, 10'd0, ST_ZERO,    32'd0},
      '{FUNC_ALLOC,  10'd0,     1'b0, 10'd0, ST_DONE,    32'd0},
      '{FUNC_ROW,    10'd0,     1'b0, 10'd0, ST_DONE,    32'd0}
   };

   page_free_list_allocator_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_page_id     (req_page_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_page_id_res (rsp_page_id_res),
      .rsp_status      (rsp_status),
      .rsp_row_id      (rsp_row_id)
   );

   always #1 clock = ~clock;

   // Apply one request to the mirror state and return its result
   function automatic alloc_result_type allocator_next(input func_type f,
                                                       input page_id_type p);
      alloc_result_type r;
      r = '0;
      r.status = ST_DONE;
      case (f)
         FUNC_ALLOC: begin
            if (list_head != '0) begin
               r.page = list_head;
               page_on_list[list_head] = 1'b0;
               list_head = link_of_page[r.page];
            end else if (fresh_page < FRESH_LIMIT) begin
               r.page = page_id_type'(fresh_page);
               page_on_list[r.page] = 1'b0;
               fresh_page = fresh_page + 1'b1;
            end else begin
               r.status = ST_FULL;
            end
         end
         FUNC_FREE: begin
            if (p == '0 || fresh_type'(p) >= fresh_page) begin
               r.status = ST_ZERO;
            end else if (page_on_list[p]) begin
               r.status = ST_ALREADY;
            end else begin
               link_of_page[p] = list_head;
               list_head = p;
               page_on_list[p] = 1'b1;
            end
         end
         FUNC_ROW: begin
            r.row = row_counter;
            row_counter = row_counter + 1'b1;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Draw a random request; alloc_pct sets the share of allocations
   function automatic void draw_request(input int alloc_pct, output func_type f,
                                        output page_id_type p);
      int roll;
      int pick;
      page_id_type cand;
      roll = $urandom_range(0, 99);
      p = page_id_type'($urandom);
      if (roll < alloc_pct) begin
         f = FUNC_ALLOC;
      end else if (roll < alloc_pct + (100 - alloc_pct) * 3 / 5) begin
         f = FUNC_FREE;
         pick = $urandom_range(0, 99);
         if (pick < 70 && fresh_page > FRESH_FIRST) begin
            // free a page that is handed out, if one can be found quickly
            for (int k = 0; k < 8; k++) begin
               cand = page_id_type'($urandom_range(1, int'(fresh_page) - 1));
               p = cand;
               if (!page_on_list[cand]) break;
            end
         end else if (pick < 85 && list_head != '0) begin
            p = list_head;
            for (int k = 0; k < 4; k++) begin
               cand = page_id_type'($urandom_range(1, int'(fresh_page) - 1));
               if (page_on_list[cand]) p = cand;
            end
         end else if (pick < 92) begin
            p = '0;
         end
      end else if (roll < 97) begin
         f = FUNC_ROW;
      end else begin
         f = FUNC_UNUSED;
      end
   endfunction

   // Present one beat at a falling edge and hold it until taken
   task automatic send_beat(input func_type f, input page_id_type p,
                            input logic typed, input alloc_result_type exp);
      start        <= 1'b1;
      req_func     <= f;
      req_page_id  <= p;
      use_typed    <= typed;
      typed_result <= exp;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   // Drop start for a random burst now and then
   task automatic maybe_idle(input logic allow);
      if (allow && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   // Check results first, then predict the beat taken at this edge
   always @(posedge clock) begin
      alloc_result_type want;
      alloc_result_type got;
      if (!reset && rsp_strobe === 1'b1) begin
         got = '{rsp_page_id_res, rsp_status, rsp_row_id};
         if (pending_results.size() == 0) begin
            $display("%0t: result with none pending: page %0d status %0d row %0d",
                     $time, got.page, got.status, got.row);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.page !== want.page) begin
               $display("%0t: rsp_page_id_res expected %0d got %0d",
                        $time, want.page, got.page);
               error_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: rsp_status expected %0d got %0d",
                        $time, want.status, got.status);
               error_count++;
            end
            if (got.row !== want.row) begin
               $display("%0t: rsp_row_id expected %0d got %0d",
                        $time, want.row, got.row);
               error_count++;
            end
         end
      end
      if (!reset && start && busy === 1'b0) begin
         want = allocator_next(req_func, req_page_id);
         beats_accepted++;
         if (want.status == ST_FULL) full_count++;
         if (want.status == ST_ZERO) ignored_count++;
         if (want.status == ST_ALREADY) already_count++;
         if (use_typed) want = typed_result;
         pending_results.push_back(want);
      end
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results pending", $time, pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      func_type    f;
      page_id_type p;
      int          n;
      list_head   = '0;
      fresh_page  = FRESH_FIRST;
      row_counter = '0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
         link_of_page[i] = '0;
         page_on_list[i] = 1'b0;
      end

      // Hold reset, then release it on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats: edge cases first
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_beat(directed_beats[i].func, directed_beats[i].page,
                   directed_beats[i].typed,
                   '{directed_beats[i].exp_page, directed_beats[i].exp_status,
                     directed_beats[i].exp_row});
         maybe_idle(1'b1);
      end

      // Fill the store with an allocation-heavy mix until fresh pages run out or FILL_CAP beats are sent
      n = 0;
      while (fresh_page < FRESH_LIMIT && n < FILL_CAP) begin
         draw_request(80, f, p);
         send_beat(f, p, 1'b0, '0);
         maybe_idle(1'b1);
         n++;
      end

      // Churn at full: pops, pushes, double frees and out-of-pages
      for (int i = 0; i < FULL_BEATS; i++) begin
         draw_request(35, f, p);
         send_beat(f, p, 1'b0, '0);
         maybe_idle(i < FULL_BEATS - CALM_BEATS);
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Checked %0d results from %0d beats, %0d fresh pages used.",
               results_checked, beats_accepted, int'(fresh_page) - 1);
      $display("Out of pages %0d, ignored frees %0d, double frees %0d.",
               full_count, ignored_count, already_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
